/* rtl/wsd_pkg.sv */
`timescale 1ns / 1ps
package wsd_pkg;

	localparam int unsigned LENGTH_COUNT_BITS = 24;
	localparam int unsigned MAX_LEN_BITS      = 24;
	localparam int unsigned EXT_LEN_BITS      = 64;

	localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = MAX_LEN_BITS'(8 * 1024 * 1024);

	localparam logic [3:0] OPC_BINARY = 4'h2;
	localparam logic [3:0] OPC_CLOSE  = 4'h8;
	localparam logic [3:0] OPC_PING   = 4'h9;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	localparam logic [1:0] CH_DATA  = 2'd0;
	localparam logic [1:0] CH_PONG  = 2'd1;
	localparam logic [1:0] CH_CLOSE = 2'd2;
	localparam logic [1:0] CH_ABORT = 2'd3;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic [1:0] channel;
		logic       last;
	} wsd_result_t;

endpackage

/* rtl/wsd_rx_if.sv */
`timescale 1ns / 1ps
interface wsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/wsd_msg_if.sv */
`timescale 1ns / 1ps
interface wsd_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic [1:0] channel;
	logic       last;

	modport source (output valid, output payload_byte, output has_byte, output channel,
		output last, input ready);
	modport sink (input valid, input payload_byte, input has_byte, input channel,
		input last, output ready);
endinterface

/* rtl/wsd_in_stage.sv */
`timescale 1ns / 1ps
module wsd_in_stage
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	wsd_rx_if.sink     rx,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

/* rtl/wsd_parser.sv */
`timescale 1ns / 1ps
module wsd_parser
	import wsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              byte_s1,
	input  logic [MAX_LEN_BITS-1:0] max_len,
	output logic                    res_valid,
	output wsd_result_t             res
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD,
		PH_STOPPED
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic                         final_q, final_d;
	logic [3:0]                   opcode_q, opcode_d;
	logic                         masked_q, masked_d;
	logic [3:0]                   hdr_left_q, hdr_left_d;
	logic [EXT_LEN_BITS-1:0]      acc_q, acc_d;
	logic [31:0]                  key_q, key_d;
	logic [1:0]                   key_pos_q, key_pos_d;
	logic [LENGTH_COUNT_BITS-1:0] remain_q, remain_d;

	logic       after_len;
	logic       finish;
	logic [6:0] len7;
	logic [7:0] key_byte;
	logic       is_last;
	logic       is_data;

	assign len7    = byte_s1[6:0];
	assign is_data = (opcode_q <= OPC_BINARY);

	always_comb begin
		case (key_pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		final_d    = final_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		hdr_left_d = hdr_left_q;
		acc_d      = acc_q;
		key_d      = key_q;
		key_pos_d  = key_pos_q;
		remain_d   = remain_q;
		after_len  = 1'b0;
		finish     = 1'b0;
		is_last    = 1'b0;
		res_valid  = 1'b0;
		res        = '0;

		case (phase_q)
			PH_HDR0: begin
				final_d  = byte_s1[7];
				opcode_d = byte_s1[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = byte_s1[7];
				if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
					acc_d      = '0;
					hdr_left_d = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase_d    = PH_EXTLEN;
				end else begin
					acc_d     = EXT_LEN_BITS'(len7);
					after_len = 1'b1;
				end
			end
			PH_EXTLEN: begin
				acc_d      = {acc_q[EXT_LEN_BITS-9:0], byte_s1};
				hdr_left_d = hdr_left_q - 4'd1;
				after_len  = (hdr_left_d == 4'd0);
			end
			PH_KEY: begin
				key_d      = {key_q[23:0], byte_s1};
				hdr_left_d = hdr_left_q - 4'd1;
				finish     = (hdr_left_d == 4'd0);
			end
			PH_PAYLOAD: begin
				key_pos_d = key_pos_q + 2'd1;
				remain_d  = remain_q - LENGTH_COUNT_BITS'(1);
				is_last   = (remain_d == '0);
				if (is_last) begin
					phase_d = PH_HDR0;
				end
				res.payload_byte = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
				res.has_byte     = 1'b1;
				if (is_data) begin
					res_valid   = 1'b1;
					res.channel = CH_DATA;
					res.last    = is_last && final_q;
				end else if (opcode_q == OPC_PING) begin
					res_valid   = 1'b1;
					res.channel = CH_PONG;
					res.last    = is_last;
				end else if (opcode_q == OPC_CLOSE) begin
					res_valid   = 1'b1;
					res.channel = CH_CLOSE;
					res.last    = is_last;
					if (is_last) begin
						phase_d = PH_STOPPED;
					end
				end else begin
					res = '0;
				end
			end
			default: begin
			end
		endcase

		if (after_len) begin
			if (masked_d) begin
				hdr_left_d = KEY_BYTES;
				key_d      = '0;
				phase_d    = PH_KEY;
			end else begin
				finish = 1'b1;
			end
		end

		if (finish) begin
			if (acc_d > EXT_LEN_BITS'(max_len)) begin
				phase_d   = PH_STOPPED;
				res_valid = 1'b1;
				res       = '{payload_byte: 8'h00, has_byte: 1'b0, channel: CH_ABORT,
					last: 1'b1};
			end else begin
				remain_d  = acc_d[LENGTH_COUNT_BITS-1:0];
				key_pos_d = 2'd0;
				if (remain_d != '0) begin
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_HDR0;
					if (opcode_d <= OPC_BINARY) begin
						res_valid = final_d;
						res       = '{payload_byte: 8'h00, has_byte: 1'b0,
							channel: CH_DATA, last: 1'b1};
					end else if (opcode_d == OPC_PING) begin
						res_valid = 1'b1;
						res       = '{payload_byte: 8'h00, has_byte: 1'b0,
							channel: CH_PONG, last: 1'b1};
					end else if (opcode_d == OPC_CLOSE) begin
						phase_d   = PH_STOPPED;
						res_valid = 1'b1;
						res       = '{payload_byte: 8'h00, has_byte: 1'b0,
							channel: CH_CLOSE, last: 1'b1};
					end
				end
			end
		end

		if (!take) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			final_q    <= 1'b0;
			opcode_q   <= '0;
			masked_q   <= 1'b0;
			hdr_left_q <= '0;
			acc_q      <= '0;
			key_q      <= '0;
			key_pos_q  <= '0;
			remain_q   <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			final_q    <= final_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			hdr_left_q <= hdr_left_d;
			acc_q      <= acc_d;
			key_q      <= key_d;
			key_pos_q  <= key_pos_d;
			remain_q   <= remain_d;
		end
	end

endmodule

/* rtl/wsd_out_stage.sv */
`timescale 1ns / 1ps
module wsd_out_stage
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  wsd_result_t res,
	output logic        can_load,
	wsd_msg_if.source   msg
);

	logic        valid_q;
	wsd_result_t res_q;

	assign can_load = !valid_q || msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	assign msg.valid        = valid_q;
	assign msg.payload_byte = res_q.payload_byte;
	assign msg.has_byte     = res_q.has_byte;
	assign msg.channel      = res_q.channel;
	assign msg.last         = res_q.last;

endmodule

/* rtl/websocket_frame_deframer_top.sv */
// Channel     Direction  Payload                                  Handshake
// rx          in         rx_byte[7:0]                             valid / ready
// msg         out        payload_byte, has_byte, channel, last    valid / ready
// cfg         in         cfg_wdata[23:0] (max payload length)     cfg_we, no wait
//
// A byte is accepted per cycle unless msg stalls; its result, if any, is registered for msg.
// The rate is set by the combinational parser step between the input and result registers.
// Reset clears the parser to the first header byte and the length limit to 8 MiB.
// A msg stall holds the result register and drops rx.ready while the input register is full.
// After a close or an oversize abort, bytes are taken and dropped until reset.
`timescale 1ns / 1ps
module websocket_frame_deframer_top
	import wsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	wsd_rx_if.sink                  rx,
	wsd_msg_if.source               msg,
	input  logic                    cfg_we,
	input  logic [MAX_LEN_BITS-1:0] cfg_wdata
);

	logic [MAX_LEN_BITS-1:0] max_len_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    can_load;
	logic                    take;
	logic                    res_valid;
	wsd_result_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	assign take = valid_s1 && can_load;

	wsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_s1   (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.can_load (can_load),
		.msg      (msg)
	);

endmodule

/* rtl/wsd_checker.sv */
`timescale 1ns / 1ps
module wsd_checker
	import wsd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_ready,
	input logic [7:0] msg_payload_byte,
	input logic       msg_has_byte,
	input logic [1:0] msg_channel,
	input logic       msg_last
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> msg_valid)
		else $error("msg valid dropped while stalled");

	// Events without a byte carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_has_byte |-> msg_payload_byte == 8'h00)
		else $error("nonzero payload_byte without has_byte");

	// An abort is a single bare event that ends the stream.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_channel == CH_ABORT |-> msg_last && !msg_has_byte)
		else $error("malformed abort transaction");

	// Nothing follows an abort or the end of a close payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_last &&
		(msg_channel == CH_ABORT || msg_channel == CH_CLOSE) |=> !msg_valid)
		else $error("transaction after session end");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.msg_valid        (msg.valid),
	.msg_ready        (msg.ready),
	.msg_payload_byte (msg.payload_byte),
	.msg_has_byte     (msg.has_byte),
	.msg_channel      (msg.channel),
	.msg_last         (msg.last)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
	import wsd_pkg::*;

	localparam logic [3:0] OPC_CONT = 4'h0;
	localparam logic [3:0] OPC_TEXT = 4'h1;
	localparam logic [3:0] OPC_PONG = 4'hA;
	localparam logic [3:0] OPC_RSVD_DATA_LO = 4'h3;
	localparam logic [3:0] OPC_RSVD_DATA_HI = 4'h7;
	localparam logic [3:0] OPC_RSVD_CTRL_LO = 4'hB;
	localparam logic [3:0] OPC_RSVD_CTRL_HI = 4'hF;

	localparam logic [1:0] FORM_7  = 2'd0;
	localparam logic [1:0] FORM_16 = 2'd1;
	localparam logic [1:0] FORM_64 = 2'd2;

	localparam int unsigned END_CLOSE   = 0;
	localparam int unsigned END_ABORT16 = 1;
	localparam int unsigned END_ABORT64 = 2;

	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 2000;

	typedef enum logic [2:0] {
		P_HDR0,
		P_HDR1,
		P_EXTLEN,
		P_KEY,
		P_PAYLOAD,
		P_STOPPED
	} parse_phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MAX_LEN_BITS-1:0] cfg_wdata;

	wsd_rx_if rx();
	wsd_msg_if msg();

	websocket_frame_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.msg(msg),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	parse_phase_t phase;
	logic fin;
	logic [3:0] opc;
	logic masked;
	logic [3:0] hdr_left;
	logic [63:0] len_acc;
	logic [31:0] key;
	logic [1:0] key_idx;
	logic [LENGTH_COUNT_BITS-1:0] remaining;
	logic [MAX_LEN_BITS-1:0] len_limit;

	logic [7:0] byte_q[$];
	wsd_result_t expect_q[$];

	logic rx_fire;
	logic msg_fire;
	int unsigned send_gap;
	int unsigned send_burst;
	int unsigned take_stall;
	int unsigned take_burst;
	int hold_left;
	bit pressure_done;
	int stuck;

	int unsigned n_bytes;
	int unsigned n_results;
	int unsigned n_frames;
	int unsigned n_limits;
	int unsigned n_queued;
	int unsigned errors;
	string ending;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_parser();
		phase = P_HDR0;
		fin = 1'b0;
		opc = '0;
		masked = 1'b0;
		hdr_left = '0;
		len_acc = '0;
		key = '0;
		key_idx = '0;
		remaining = '0;
		len_limit = MAX_LEN_RESET;
	endfunction

	function automatic bit header_done(output wsd_result_t res);
		res = '0;
		if (len_acc > 64'(len_limit)) begin
			phase = P_STOPPED;
			res = {8'd0, 1'b0, CH_ABORT, 1'b1};
			return 1'b1;
		end
		remaining = len_acc[LENGTH_COUNT_BITS-1:0];
		key_idx = '0;
		if (remaining != '0) begin
			phase = P_PAYLOAD;
			return 1'b0;
		end
		phase = P_HDR0;
		if (opc <= OPC_BINARY) begin
			res = {8'd0, 1'b0, CH_DATA, 1'b1};
			return fin;
		end
		if (opc == OPC_PING) begin
			res = {8'd0, 1'b0, CH_PONG, 1'b1};
			return 1'b1;
		end
		if (opc == OPC_CLOSE) begin
			phase = P_STOPPED;
			res = {8'd0, 1'b0, CH_CLOSE, 1'b1};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit length_done(output wsd_result_t res);
		res = '0;
		if (masked) begin
			hdr_left = KEY_BYTES;
			key = '0;
			phase = P_KEY;
			return 1'b0;
		end
		return header_done(res);
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output wsd_result_t res);
		logic [7:0] d;
		logic at_end;
		res = '0;
		d = b;
		case (phase)
			P_HDR0: begin
				fin = b[7];
				opc = b[3:0];
				phase = P_HDR1;
			end
			P_HDR1: begin
				masked = b[7];
				len_acc = '0;
				if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
					hdr_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase = P_EXTLEN;
				end else begin
					len_acc = 64'(b[6:0]);
					return length_done(res);
				end
			end
			P_EXTLEN: begin
				len_acc = {len_acc[55:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == '0)
					return length_done(res);
			end
			P_KEY: begin
				key = {key[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == '0)
					return header_done(res);
			end
			P_PAYLOAD: begin
				if (masked)
					d = b ^ key[8 * (3 - int'(key_idx)) +: 8];
				key_idx = key_idx + 2'd1;
				remaining = remaining - 1'b1;
				at_end = (remaining == '0);
				if (at_end)
					phase = P_HDR0;
				if (opc <= OPC_BINARY) begin
					res = {d, 1'b1, CH_DATA, fin & at_end};
					return 1'b1;
				end
				if (opc == OPC_PING) begin
					res = {d, 1'b1, CH_PONG, at_end};
					return 1'b1;
				end
				if (opc == OPC_CLOSE) begin
					if (at_end)
						phase = P_STOPPED;
					res = {d, 1'b1, CH_CLOSE, at_end};
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic int unsigned next_idle(inout int unsigned burst);
		int unsigned r;
		if (burst != 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		byte_q.push_back(b);
		n_queued++;
	endtask

	task automatic push_frame(input logic f, input logic [3:0] op, input logic [2:0] rsv,
		input logic msk, input logic [1:0] form, input logic [63:0] len,
		input int unsigned body);
		logic [31:0] k;
		k = $urandom();
		push_byte({f, rsv, op});
		case (form)
			FORM_7: push_byte({msk, len[6:0]});
			FORM_16: begin
				push_byte({msk, LEN7_EXT16});
				push_byte(len[15:8]);
				push_byte(len[7:0]);
			end
			default: begin
				push_byte({msk, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					push_byte(len[8 * i +: 8]);
			end
		endcase
		if (msk)
			for (int i = 3; i >= 0; i--)
				push_byte(k[8 * i +: 8]);
		for (int unsigned i = 0; i < body; i++)
			push_byte(8'($urandom()));
		n_frames++;
	endtask

	task automatic random_frame(input int unsigned cap);
		logic [3:0] op;
		logic [1:0] form;
		int unsigned len;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			op = 4'($urandom_range(OPC_CONT, OPC_BINARY));
		else if (r < 70)
			op = OPC_PING;
		else if (r < 85)
			op = OPC_PONG;
		else if (r < 93)
			op = 4'($urandom_range(OPC_RSVD_DATA_LO, OPC_RSVD_DATA_HI));
		else
			op = 4'($urandom_range(OPC_RSVD_CTRL_LO, OPC_RSVD_CTRL_HI));
		r = $urandom_range(0, 99);
		if (r < 60)
			len = $urandom_range(0, 12);
		else if (r < 85)
			len = $urandom_range(0, 40);
		else if (r < 95)
			len = $urandom_range(0, 300);
		else
			len = cap;
		if (len > cap)
			len = cap;
		r = $urandom_range(0, 99);
		if (len > 125)
			form = (r < 75) ? FORM_16 : FORM_64;
		else if (r < 60)
			form = FORM_7;
		else if (r < 85)
			form = FORM_16;
		else
			form = FORM_64;
		push_frame($urandom_range(0, 3) != 0, op, 3'($urandom()), 1'($urandom_range(0, 1)),
			form, 64'(len), len);
	endtask

	task automatic random_phase(input int unsigned cap, input int unsigned n);
		int unsigned start;
		start = n_queued;
		while (n_queued - start < n)
			random_frame(cap);
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [MAX_LEN_BITS-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		len_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_limits++;
	endtask

	always @(negedge clk) begin
		logic v;
		if (rx_fire) begin
			void'(byte_q.pop_front());
			send_gap = next_idle(send_burst);
		end
		v = 1'b0;
		if (!arst_n)
			v = 1'b0;
		else if (send_gap != 0)
			send_gap--;
		else if (byte_q.size() != 0)
			v = 1'b1;
		rx.valid <= v;
		if (v)
			rx.rx_byte <= byte_q[0];
	end

	always @(negedge clk) begin
		logic r;
		if (msg_fire)
			take_stall = next_idle(take_burst);
		if (!pressure_done && arst_n && n_bytes > 100 && byte_q.size() > 50) begin
			pressure_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		r = 1'b0;
		if (!arst_n)
			r = 1'b0;
		else if (hold_left != 0)
			hold_left--;
		else if (take_stall != 0)
			take_stall--;
		else
			r = 1'b1;
		msg.ready <= r;
	end

	always @(posedge clk) begin
		wsd_result_t got;
		wsd_result_t want;
		rx_fire <= arst_n && rx.valid && rx.ready;
		msg_fire <= arst_n && msg.valid && msg.ready;
		if (arst_n && msg.valid && msg.ready) begin
			got = {msg.payload_byte, msg.has_byte, msg.channel, msg.last};
			if (expect_q.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: byte %02h has %0b ch %0d last %0b",
						got.payload_byte, got.has_byte, got.channel, got.last);
				errors++;
			end else begin
				want = expect_q.pop_front();
				if (got.payload_byte !== want.payload_byte || got.has_byte !== want.has_byte ||
					got.channel !== want.channel || got.last !== want.last) begin
					if (errors < 10)
						$display({"mismatch at result %0d: expected byte %02h has %0b ch %0d ",
							"last %0b, got byte %02h has %0b ch %0d last %0b"}, n_results,
							want.payload_byte, want.has_byte, want.channel, want.last,
							got.payload_byte, got.has_byte, got.channel, got.last);
					errors++;
				end
			end
			n_results++;
		end
		if (arst_n && rx.valid && rx.ready) begin
			n_bytes++;
			if (deframe_byte(rx.rx_byte, want))
				expect_q.push_back(want);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx.valid && rx.ready) || (msg.valid && msg.ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= WATCHDOG_CYCLES) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned n;
		logic [MAX_LEN_BITS-1:0] mid_limit;
		logic [63:0] big_len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		msg.ready = 1'b0;
		rx_fire = 1'b0;
		msg_fire = 1'b0;
		send_gap = 0;
		send_burst = 0;
		take_stall = 0;
		take_burst = 0;
		hold_left = 0;
		pressure_done = 1'b0;
		stuck = 0;
		n_bytes = 0;
		n_results = 0;
		n_frames = 0;
		n_limits = 0;
		n_queued = 0;
		errors = 0;
		reset_parser();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_frame(1'b1, OPC_TEXT, 3'b000, 1'b0, FORM_7, 64'd0, 0);
		push_frame(1'b0, OPC_BINARY, 3'b111, 1'b0, FORM_7, 64'd0, 0);
		push_frame(1'b1, OPC_PING, 3'b000, 1'b0, FORM_16, 64'd0, 0);
		push_frame(1'b1, OPC_PONG, 3'b000, 1'b0, FORM_7, 64'd1, 1);
		push_frame(1'b1, OPC_BINARY, 3'b000, 1'b0, FORM_7, 64'd2, 0);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_frame(1'b1, OPC_CONT, 3'b101, 1'b1, FORM_64, 64'd1, 1);
		drain();

		set_limit('0);
		random_phase(0, 60);
		// The limit changes while a frame header is half received.
		push_byte({1'b1, 3'b000, OPC_TEXT});
		push_byte({1'b1, LEN7_EXT16});
		push_byte(8'h00);
		drain();
		set_limit(MAX_LEN_BITS'(3));
		push_byte(8'h03);
		repeat (7) push_byte(8'($urandom()));
		n_frames++;
		random_phase(3, 40);
		drain();

		set_limit('1);
		random_phase(300, 150);
		drain();

		mid_limit = MAX_LEN_BITS'($urandom_range(20, 200));
		set_limit(mid_limit);
		random_phase(32'(mid_limit), 100);
		drain();

		pick = $urandom_range(END_CLOSE, END_ABORT64);
		if (pick == END_CLOSE) begin
			ending = "a close frame";
			n = $urandom_range(0, 5);
			push_frame(1'b1, OPC_CLOSE, 3'b000, 1'($urandom_range(0, 1)), FORM_7, 64'(n), n);
		end else if (pick == END_ABORT16) begin
			ending = "an oversize abort";
			push_frame(1'b1, OPC_BINARY, 3'b000, 1'($urandom_range(0, 1)), FORM_16,
				64'(mid_limit) + 64'd1, 0);
		end else begin
			ending = "an oversize abort with a 64-bit length";
			big_len = 64'h8000_0000_0000_0000 | 64'($urandom_range(0, 32'(mid_limit)));
			push_frame(1'b1, OPC_TEXT, 3'b000, 1'($urandom_range(0, 1)), FORM_64, big_len, 0);
		end
		repeat (10) push_byte(8'($urandom()));
		drain();
		repeat (8) @(posedge clk);

		$display("summary: %0d bytes in %0d frames, %0d results checked, %0d mismatches",
			n_bytes, n_frames, n_results, errors);
		$display("summary: %0d length limits written, session ended by %s", n_limits, ending);
		if (errors == 0 && expect_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/wsd_pkg.sv
rtl/wsd_rx_if.sv
rtl/wsd_msg_if.sv
rtl/wsd_in_stage.sv
rtl/wsd_parser.sv
rtl/wsd_out_stage.sv
rtl/websocket_frame_deframer_top.sv
rtl/wsd_checker.sv
tb/tb.sv
